@@ design/bpl_pkg.sv @@
// shared types and constants for the bounded positional list
package bpl_pkg;

  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] FAIL_VALUE = 32'hFFFF_FFFF;
  localparam logic             STATUS_OK  = 1'b0;
  localparam logic             STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic load_req;
    logic exec;
  } ctl_cmd_t;

endpackage

@@ design/bpl_ctrl.sv @@
// controller: request sequencing and output valid tracking
module bpl_ctrl
  import bpl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.load_req = 1'b0;
    cmd_o.exec     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result register must be free or draining this cycle
        cmd_o.exec = !out_valid_q || out_ready_i;
        if (cmd_o.exec) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("result not presented after execute");

  a_load_enters_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> (state_q == ST_EXEC) && !in_ready_o)
    else $error("accepted item did not enter execute");

  a_stall_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && out_valid_o && !out_ready_i |=> state_q == ST_EXEC)
    else $error("executed while result register was blocked");
`endif

endmodule

@@ design/bpl_datapath.sv @@
// datapath: shifting entry cells, count, capacity and result registers
module bpl_datapath
  import bpl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctl_cmd_t                cmd_i,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic [1:0]              action_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    status_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [POS_W-1:0]        entry_count_o,
  output logic                    empty_flag_o,
  output logic                    is_full_flag_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] DEPTH_X = CMPW'(DEPTH);

  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    total_q, total_d;
  logic [VAL_W-1:0] store_q [DEPTH];
  logic [VAL_W-1:0] store_d [DEPTH];

  action_e          req_act_q;
  logic [POS_W-1:0] req_pos_q;
  logic [VAL_W-1:0] req_val_q;

  logic             status_q, status_d;
  logic [VAL_W-1:0] rdval_q, rdval_d;
  logic [POS_W-1:0] count_q;
  logic             empty_q, full_q;

  logic [CMPW-1:0] pos_x, tot_x, cap_x, cap_eff, tot_new_x;
  logic            pos_ok, ins_ok, do_set, do_ins, do_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      total_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_act_q <= action_e'(action_i);
      req_pos_q <= position_i;
      req_val_q <= value_i;
    end
  end

  assign pos_x   = CMPW'(req_pos_q);
  assign tot_x   = CMPW'(total_q);
  assign cap_x   = CMPW'(cap_q);
  assign cap_eff = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
  assign pos_ok  = pos_x < tot_x;
  assign ins_ok  = (tot_x < cap_eff) && (pos_x <= tot_x);

  always_comb begin
    do_set   = 1'b0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    status_d = STATUS_OK;
    rdval_d  = '0;
    total_d  = total_q;
    unique case (req_act_q)
      ACT_GET: begin
        if (pos_ok) begin
          rdval_d = store_q[IW'(pos_x)];
        end else begin
          status_d = STATUS_ERR;
          rdval_d  = FAIL_VALUE;
        end
      end
      ACT_SET: begin
        do_set   = pos_ok;
        status_d = pos_ok ? STATUS_OK : STATUS_ERR;
      end
      ACT_INSERT: begin
        do_ins   = ins_ok;
        status_d = ins_ok ? STATUS_OK : STATUS_ERR;
        if (ins_ok) begin
          total_d = total_q + CW'(1);
        end
      end
      ACT_REMOVE: begin
        do_rem   = pos_ok;
        status_d = pos_ok ? STATUS_OK : STATUS_ERR;
        if (pos_ok) begin
          total_d = total_q - CW'(1);
        end
      end
      default: begin
        status_d = STATUS_ERR;
      end
    endcase
  end

  assign tot_new_x = CMPW'(total_d);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMPW-1:0] IDX = CMPW'(i);
    logic [VAL_W-1:0] lower_w, upper_w;
    if (i == 0) begin : g_lo_edge
      assign lower_w = store_q[i];
    end else begin : g_lo
      assign lower_w = store_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_edge
      assign upper_w = store_q[i];
    end else begin : g_hi
      assign upper_w = store_q[i+1];
    end
    always_comb begin
      store_d[i] = store_q[i];
      if ((do_set || do_ins) && (IDX == pos_x)) begin
        store_d[i] = req_val_q;
      end else if (do_ins && (IDX > pos_x) && (IDX <= tot_x)) begin
        store_d[i] = lower_w;
      end else if (do_rem && (IDX >= pos_x) && (IDX + CMPW'(1) < tot_x)) begin
        store_d[i] = upper_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      store_q  <= store_d;
      status_q <= status_d;
      rdval_q  <= rdval_d;
      count_q  <= tot_new_x[POS_W-1:0];
      empty_q  <= (tot_new_x == '0);
      full_q   <= (tot_new_x >= cap_eff);
    end
  end

  assign status_o       = status_q;
  assign read_value_o   = rdval_q;
  assign entry_count_o  = count_q;
  assign empty_flag_o   = empty_q;
  assign is_full_flag_o = full_q;

endmodule

@@ design/bounded_positional_list.sv @@
// top level of the bounded positional list
// item registered on accept, run in ST_EXEC, result registered; out_ready_i can stall
// a new item is taken only in idle, after the execute step of the last one
// insert and remove shift the entry cells in the execute step
// reset: length cleared (output count/flags not reset), capacity 16, cells unwritten
module bounded_positional_list
  import bpl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    status_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [POS_W-1:0]        entry_count_o,
  output logic                    empty_flag_o,
  output logic                    is_full_flag_o
);

  ctl_cmd_t cmd;

  bpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bpl_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .entry_count_o  (entry_count_o),
    .empty_flag_o   (empty_flag_o),
    .is_full_flag_o (is_full_flag_o)
  );

endmodule

@@ dv/tb_bounded_positional_list.sv @@
// testbench for the bounded positional list: directed and random actions checked against a list model
module tb_bounded_positional_list;
  import bpl_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] read_value;
    logic [POS_W-1:0] entry_count;
    logic             empty_flag;
    logic             is_full;
  } list_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  action_e                 action_i    = ACT_GET;
  logic [POS_W-1:0]        position_i  = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    status_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic [POS_W-1:0]        entry_count_o;
  logic                    empty_flag_o;
  logic                    is_full_flag_o;

  // list model state
  logic [VAL_W-1:0] list_cells [DEPTH];
  int unsigned      list_len = 0;
  logic [CAP_W-1:0] list_cap = CAP_RESET;

  list_result_t pending_results [$];
  int unsigned  error_count    = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  rx_hold_cycles = 0;
  bit           tx_gaps_on     = 1'b0;
  bit           rx_gaps_on     = 1'b0;

  bounded_positional_list #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .entry_count_o  (entry_count_o),
    .empty_flag_o   (empty_flag_o),
    .is_full_flag_o (is_full_flag_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic list_result_t apply_list_op(action_e act, logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  cap_eff;
    r = '0;
    r.status = STATUS_OK;
    cap_eff = (list_cap > DEPTH) ? DEPTH : list_cap;
    case (act)
      ACT_GET: begin
        if (pos < list_len) begin
          r.read_value = list_cells[pos];
        end else begin
          r.status     = STATUS_ERR;
          r.read_value = FAIL_VALUE;
        end
      end
      ACT_SET: begin
        if (pos < list_len) list_cells[pos] = val;
        else r.status = STATUS_ERR;
      end
      ACT_INSERT: begin
        if (list_len >= cap_eff || pos > list_len || list_len >= DEPTH) begin
          r.status = STATUS_ERR;
        end else begin
          for (int i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = val;
          list_len++;
        end
      end
      default: begin
        if (pos < list_len) begin
          for (int i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end else begin
          r.status = STATUS_ERR;
        end
      end
    endcase
    r.entry_count = POS_W'(list_len);
    r.empty_flag  = (list_len == 0);
    r.is_full     = (list_len >= cap_eff);
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    error_count++;
    $display("mismatch in %s: got %h, want %h", what, got, want);
  endtask

  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch("result with nothing pending", read_value_o, '0);
      return;
    end
    want = pending_results.pop_front();
    if (status_o !== want.status)
      flag_mismatch("status", VAL_W'(status_o), VAL_W'(want.status));
    if (read_value_o !== want.read_value) flag_mismatch("read_value", read_value_o, want.read_value);
    if (entry_count_o !== want.entry_count)
      flag_mismatch("entry_count", VAL_W'(entry_count_o), VAL_W'(want.entry_count));
    if (empty_flag_o !== want.empty_flag)
      flag_mismatch("empty flag", VAL_W'(empty_flag_o), VAL_W'(want.empty_flag));
    if (is_full_flag_o !== want.is_full)
      flag_mismatch("is_full", VAL_W'(is_full_flag_o), VAL_W'(want.is_full));
  endtask

  // result side: random stalls per item plus long holds on request
  initial begin : result_side
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_result();
        if (rx_gaps_on) wait_left = $urandom_range(0, 7);
      end
      if (rx_hold_cycles != 0) begin
        rx_hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(action_e act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_list_op(act, pos, val));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_wdata_i <= cap;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    list_cap = cap;
  endtask

  task automatic send_random_op();
    action_e          act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) act = ACT_INSERT;
    else if (pick < 55) act = ACT_REMOVE;
    else if (pick < 78) act = ACT_GET;
    else act = ACT_SET;
    if ($urandom_range(0, 6) == 0) pos = POS_W'($urandom_range(0, 31));
    else pos = POS_W'($urandom_range(0, list_len));
    case ($urandom_range(0, 9))
      0: val = 32'h7FFF_FFFF;
      1: val = 32'h8000_0000;
      2: val = FAIL_VALUE;
      3: val = '0;
      default: val = $urandom();
    endcase
    send_item(act, pos, val);
  endtask

  task automatic test_directed_ops();
    set_capacity(CAP_RESET);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_item(ACT_GET, 0, '0);
    send_item(ACT_REMOVE, 0, '0);
    send_item(ACT_SET, 0, 32'h1234_5678);
    send_item(ACT_INSERT, 1, 32'h0000_0001);
    send_item(ACT_INSERT, 0, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 0, 32'h8000_0000);
    send_item(ACT_INSERT, 2, FAIL_VALUE);
    send_item(ACT_INSERT, 1, '0);
    for (int p = 0; p < 4; p++) send_item(ACT_GET, POS_W'(p), '0);
    send_item(ACT_GET, 5'd31, '0);
    send_item(ACT_GET, 5'd16, '0);
    send_item(ACT_SET, 4, 32'hDEAD_BEEF);
    send_item(ACT_SET, 1, 32'h5555_AAAA);
    send_item(ACT_GET, 1, '0);
    send_item(ACT_REMOVE, 4, '0);
    send_item(ACT_REMOVE, 5'd31, '0);
    send_item(ACT_REMOVE, 0, '0);
    send_item(ACT_REMOVE, 2, '0);
    send_item(ACT_GET, 0, '0);
    send_item(ACT_INSERT, 5'd16, 32'hFFFF_0000);
  endtask

  task automatic test_capacity_extremes();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    set_capacity(5'd0);
    send_item(ACT_INSERT, 0, 32'h0F0F_0F0F);
    send_item(ACT_GET, 0, '0);
    while (list_len != 0) send_item(ACT_REMOVE, 0, '0);
    send_item(ACT_INSERT, 0, 32'h0F0F_0F0F);
    set_capacity(5'd1);
    send_item(ACT_INSERT, 0, 32'hA5A5_5A5A);
    send_item(ACT_INSERT, 1, 32'h5A5A_A5A5);
    send_item(ACT_GET, 0, '0);
    send_item(ACT_REMOVE, 0, '0);
  endtask

  task automatic test_shrink_capacity();
    set_capacity(5'd31);
    while (list_len < DEPTH)
      send_item(ACT_INSERT, POS_W'($urandom_range(0, list_len)), $urandom());
    send_item(ACT_INSERT, POS_W'(list_len), $urandom());
    send_item(ACT_GET, POS_W'(DEPTH - 1), '0);
    set_capacity(5'd3);
    send_item(ACT_INSERT, 0, $urandom());
    repeat (3) send_item(ACT_GET, POS_W'($urandom_range(0, list_len - 1)), '0);
    while (list_len >= 3)
      send_item(ACT_REMOVE, POS_W'($urandom_range(0, list_len - 1)), '0);
    send_item(ACT_INSERT, POS_W'(list_len), $urandom());
    send_item(ACT_INSERT, 0, $urandom());
  endtask

  task automatic test_backpressure();
    set_capacity(5'd16);
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = 48;
    repeat (24) send_random_op();
  endtask

  task automatic test_pause_for_results();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (3) begin
      repeat (8) send_random_op();
      wait_drained();
    end
  endtask

  task automatic test_random_phases();
    logic [CAP_W-1:0] phase_caps [10];
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd16, 5'd0, 5'd12, 5'd16, 5'd4, 5'd16};
    phase_caps[6] = CAP_W'($urandom_range(1, 16));
    for (int ph = 0; ph < 10; ph++) begin
      set_capacity(phase_caps[ph]);
      tx_gaps_on = (ph % 3 != 0);
      rx_gaps_on = (ph % 4 != 1);
      repeat (105) send_random_op();
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_capacity_extremes();
    test_shrink_capacity();
    test_backpressure();
    test_pause_for_results();
    test_random_phases();
    wait_drained();
    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
